>>> rtl/cheapest_k_slot_selector_defines.svh
// Assertion macros used by the checker file.
`ifndef CHEAPEST_K_SLOT_SELECTOR_DEFINES_SVH
`define CHEAPEST_K_SLOT_SELECTOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CKS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CKS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/cks_pkg.sv
`default_nettype none
package cks_pkg;
	localparam int MAX_PICK   = 16;
	localparam int BOOK_DEPTH = 1024;
	localparam int IDX_W  = $clog2(BOOK_DEPTH);
	localparam int SLOT_W = (MAX_PICK > 1) ? $clog2(MAX_PICK) : 1;
	localparam int CNT_W  = $clog2(MAX_PICK + 1);
	localparam int COST_W = 32;
	localparam int SUM_W  = 40;
	localparam int BEN_W  = 33;
	localparam int UTIL_W = 48;
	localparam int TIME_W = 32;
	localparam int OIDX_W = 10;

	localparam logic signed [BEN_W-1:0]  BEN_MIN  = {1'b1, {(BEN_W-1){1'b0}}};
	localparam logic signed [UTIL_W-1:0] UTIL_MIN = {1'b1, {(UTIL_W-1){1'b0}}};
	localparam logic signed [UTIL_W-1:0] UTIL_MAX = {1'b0, {(UTIL_W-1){1'b1}}};

	typedef enum logic [2:0] {
		REG_PICK_COUNT,
		REG_FLOW_START,
		REG_IGNORE_TIME,
		REG_IGNORE_ENABLE,
		REG_EMIT_INDICES
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_REPLACE,
		S_UTIL,
		S_BEST,
		S_FINISH,
		S_EMIT_INIT,
		S_EMIT_ONE,
		S_EMIT_SCAN,
		S_EMIT_LOAD
	} state_t;

	typedef struct packed {
		logic load;
		logic append;
		logic scan_start;
		logic scan_step;
		logic replace;
		logic util;
		logic best;
		logic pos_inc;
		logic emit_start;
		logic emit_step;
		logic out_single;
		logic out_entry;
		logic clear_run;
	} cmd_t;

	typedef struct packed {
		logic take;
		logic not_full;
		logic scan_last;
		logic last_slot;
		logic emit_list;
		logic emit_last_cnt;
		logic final_entry;
		logic out_free;
	} sts_t;
endpackage
`default_nettype wire

>>> rtl/cks_ctrl.sv
`default_nettype none
module cks_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire cks_pkg::sts_t sts,
	output cks_pkg::cmd_t      cmd
);
	cks_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cks_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cks_pkg::S_IDLE: begin
				if (in_valid) state_d = cks_pkg::S_CHECK;
			end
			cks_pkg::S_CHECK: begin
				if (!sts.take) state_d = cks_pkg::S_FINISH;
				else if (sts.not_full) state_d = cks_pkg::S_UTIL;
				else state_d = cks_pkg::S_SCAN;
			end
			cks_pkg::S_SCAN: begin
				if (sts.scan_last) state_d = cks_pkg::S_REPLACE;
			end
			cks_pkg::S_REPLACE: state_d = cks_pkg::S_UTIL;
			cks_pkg::S_UTIL:    state_d = cks_pkg::S_BEST;
			cks_pkg::S_BEST:    state_d = cks_pkg::S_FINISH;
			cks_pkg::S_FINISH: begin
				state_d = sts.last_slot ? cks_pkg::S_EMIT_INIT : cks_pkg::S_IDLE;
			end
			cks_pkg::S_EMIT_INIT: begin
				state_d = sts.emit_list ? cks_pkg::S_EMIT_SCAN : cks_pkg::S_EMIT_ONE;
			end
			cks_pkg::S_EMIT_ONE: begin
				if (sts.out_free) state_d = cks_pkg::S_IDLE;
			end
			cks_pkg::S_EMIT_SCAN: begin
				if (sts.emit_last_cnt) state_d = cks_pkg::S_EMIT_LOAD;
			end
			cks_pkg::S_EMIT_LOAD: begin
				if (sts.out_free) begin
					state_d = sts.final_entry ? cks_pkg::S_IDLE : cks_pkg::S_EMIT_SCAN;
				end
			end
			default: state_d = cks_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			cks_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			cks_pkg::S_CHECK: begin
				cmd.append     = sts.take && sts.not_full;
				cmd.scan_start = sts.take && !sts.not_full;
			end
			cks_pkg::S_SCAN:      cmd.scan_step  = 1'b1;
			cks_pkg::S_REPLACE:   cmd.replace    = 1'b1;
			cks_pkg::S_UTIL:      cmd.util       = 1'b1;
			cks_pkg::S_BEST:      cmd.best       = 1'b1;
			cks_pkg::S_FINISH:    cmd.pos_inc    = 1'b1;
			cks_pkg::S_EMIT_INIT: cmd.emit_start = 1'b1;
			cks_pkg::S_EMIT_ONE: begin
				cmd.out_single = sts.out_free;
				cmd.clear_run  = sts.out_free;
			end
			cks_pkg::S_EMIT_SCAN: cmd.emit_step = 1'b1;
			cks_pkg::S_EMIT_LOAD: begin
				cmd.out_entry = sts.out_free;
				cmd.clear_run = sts.out_free && sts.final_entry;
			end
			default: cmd = '0;
		endcase
	end
endmodule
`default_nettype wire

>>> rtl/cks_dp.sv
`default_nettype none
module cks_dp (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire cks_pkg::cmd_t                     cmd,
	output cks_pkg::sts_t                          sts,
	input  wire logic                              cfg_valid,
	input  wire logic [2:0]                        cfg_index,
	input  wire logic [31:0]                       cfg_data,
	input  wire logic [cks_pkg::TIME_W-1:0]        slot_time,
	input  wire logic                              owned_by_user,
	input  wire logic                              has_offer,
	input  wire logic signed [cks_pkg::COST_W-1:0] offer_cost,
	input  wire logic                              last_slot,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [cks_pkg::OIDX_W-1:0]             chosen_index,
	output logic signed [cks_pkg::COST_W-1:0]      chosen_cost,
	output logic signed [cks_pkg::UTIL_W-1:0]      peak_utility,
	output logic                                   set_found,
	output logic                                   last_result
);
	localparam int SW = cks_pkg::SLOT_W;
	localparam int MP = cks_pkg::MAX_PICK;

	logic [4:0]                         pick_q;
	logic [cks_pkg::TIME_W-1:0]         flow_q, ign_time_q;
	logic                               ign_en_q, emit_q;

	logic [cks_pkg::TIME_W-1:0]         time_q;
	logic                               owned_q, offer_q, last_q;
	logic signed [cks_pkg::COST_W-1:0]  cost_in_q;

	logic signed [cks_pkg::COST_W-1:0]  heap_cost_q [MP];
	logic [cks_pkg::IDX_W-1:0]          heap_idx_q  [MP];
	logic signed [cks_pkg::COST_W-1:0]  bset_cost_q [MP];
	logic [cks_pkg::IDX_W-1:0]          bset_idx_q  [MP];

	logic [cks_pkg::CNT_W-1:0]          size_q;
	logic signed [cks_pkg::SUM_W-1:0]   sum_q;
	logic signed [cks_pkg::BEN_W-1:0]   ben_q;
	logic signed [cks_pkg::UTIL_W-1:0]  best_q;
	logic                               best_valid_q, stopped_q;
	logic [cks_pkg::IDX_W-1:0]          pos_q;

	logic [SW-1:0]                      cnt_q, max_slot_q, sel_slot_q, emit_n_q;
	logic signed [cks_pkg::COST_W-1:0]  max_cost_q, sel_cost_q;
	logic [cks_pkg::IDX_W-1:0]          max_idx_q, sel_idx_q;
	logic                               sel_valid_q;
	logic [MP-1:0]                      emitted_q;

	logic signed [cks_pkg::UTIL_W-1:0]  util_s1;
	logic                               full_s1;

	logic                               out_valid_q, out_found_q, out_last_q;
	logic [cks_pkg::OIDX_W-1:0]         out_idx_q;
	logic signed [cks_pkg::COST_W-1:0]  out_cost_q;
	logic signed [cks_pkg::UTIL_W-1:0]  out_util_q;

	logic [cks_pkg::CNT_W-1:0]          p_eff;
	logic [SW-1:0]                      p_m1;
	logic signed [cks_pkg::COST_W-1:0]  cur_cost;
	logic [cks_pkg::BEN_W:0]            ben_diff;
	logic signed [cks_pkg::BEN_W-1:0]   new_ben;
	logic signed [cks_pkg::BEN_W+15:0]  ben_fix;
	logic signed [cks_pkg::BEN_W+16:0]  util_w;
	logic signed [cks_pkg::UTIL_W-1:0]  util_sat;
	logic signed [cks_pkg::COST_W-1:0]  rd_cost, e_cost;
	logic [cks_pkg::IDX_W-1:0]          rd_idx, e_idx;
	logic                               is_max, is_min, cfg_hit, clear;

	// Effective set size: zero acts as one, large values clip to the heap depth.
	always_comb begin
		if (pick_q == 5'd0) p_eff = cks_pkg::CNT_W'(1);
		else if (32'(pick_q) > MP) p_eff = cks_pkg::CNT_W'(MP);
		else p_eff = cks_pkg::CNT_W'(pick_q);
	end
	assign p_m1 = SW'(p_eff - cks_pkg::CNT_W'(1));

	assign cur_cost  = owned_q ? '0 : cost_in_q;
	assign ben_diff  = {2'b00, flow_q} - {2'b00, time_q} - (cks_pkg::BEN_W+1)'(1);
	assign new_ben   = $signed(ben_diff[cks_pkg::BEN_W-1:0]);
	assign ben_fix   = $signed({ben_q, 16'h0000});
	assign util_w    = $signed({ben_fix[cks_pkg::BEN_W+15], ben_fix})
	                 - $signed({{(cks_pkg::BEN_W+17-cks_pkg::SUM_W){sum_q[cks_pkg::SUM_W-1]}},
	                            sum_q});

	always_comb begin
		if (util_w[cks_pkg::BEN_W+16:cks_pkg::UTIL_W-1] == '0 ||
		    util_w[cks_pkg::BEN_W+16:cks_pkg::UTIL_W-1] == '1) begin
			util_sat = util_w[cks_pkg::UTIL_W-1:0];
		end else if (util_w[cks_pkg::BEN_W+16]) begin
			util_sat = cks_pkg::UTIL_MIN;
		end else begin
			util_sat = cks_pkg::UTIL_MAX;
		end
	end

	assign rd_cost = heap_cost_q[cnt_q];
	assign rd_idx  = heap_idx_q[cnt_q];
	assign is_max  = (cnt_q == '0) || (rd_cost > max_cost_q) ||
	                 (rd_cost == max_cost_q && rd_idx > max_idx_q);
	assign e_cost  = bset_cost_q[cnt_q];
	assign e_idx   = bset_idx_q[cnt_q];
	assign is_min  = !emitted_q[cnt_q] && (!sel_valid_q || e_idx < sel_idx_q ||
	                 (e_idx == sel_idx_q && e_cost < sel_cost_q));

	assign cfg_hit = cfg_valid && (cfg_index == cks_pkg::REG_PICK_COUNT ||
	                 cfg_index == cks_pkg::REG_FLOW_START ||
	                 cfg_index == cks_pkg::REG_IGNORE_TIME ||
	                 cfg_index == cks_pkg::REG_IGNORE_ENABLE ||
	                 cfg_index == cks_pkg::REG_EMIT_INDICES);
	assign clear = cfg_hit || cmd.clear_run;

	always_comb begin
		sts.take          = !stopped_q && (owned_q || offer_q) &&
		                    !(ign_en_q && time_q == ign_time_q);
		sts.not_full      = size_q < p_eff;
		sts.scan_last     = cnt_q == SW'(size_q - cks_pkg::CNT_W'(1));
		sts.last_slot     = last_q;
		sts.emit_list     = emit_q && best_valid_q;
		sts.emit_last_cnt = cnt_q == p_m1;
		sts.final_entry   = emit_n_q == p_m1;
		sts.out_free      = !out_valid_q || out_ready;
	end

	// Configuration and run state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pick_q       <= 5'd1;
			flow_q       <= '0;
			ign_time_q   <= '0;
			ign_en_q     <= 1'b0;
			emit_q       <= 1'b1;
			size_q       <= '0;
			sum_q        <= '0;
			ben_q        <= cks_pkg::BEN_MIN;
			best_q       <= cks_pkg::UTIL_MIN;
			best_valid_q <= 1'b0;
			stopped_q    <= 1'b0;
			pos_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					cks_pkg::REG_PICK_COUNT:    pick_q     <= cfg_data[4:0];
					cks_pkg::REG_FLOW_START:    flow_q     <= cfg_data;
					cks_pkg::REG_IGNORE_TIME:   ign_time_q <= cfg_data;
					cks_pkg::REG_IGNORE_ENABLE: ign_en_q   <= cfg_data[0];
					cks_pkg::REG_EMIT_INDICES:  emit_q     <= cfg_data[0];
					default: ;
				endcase
			end
			if (clear) begin
				size_q       <= '0;
				sum_q        <= '0;
				ben_q        <= cks_pkg::BEN_MIN;
				best_q       <= cks_pkg::UTIL_MIN;
				best_valid_q <= 1'b0;
				stopped_q    <= 1'b0;
				pos_q        <= '0;
			end else begin
				if (cmd.append) begin
					size_q <= size_q + cks_pkg::CNT_W'(1);
					sum_q  <= sum_q + cks_pkg::SUM_W'(cur_cost);
					ben_q  <= new_ben;
				end
				if (cmd.replace && cur_cost < max_cost_q) begin
					sum_q <= sum_q + cks_pkg::SUM_W'(cur_cost) - cks_pkg::SUM_W'(max_cost_q);
					ben_q <= new_ben;
				end
				if (cmd.best && full_s1) begin
					if (!best_valid_q || util_s1 > best_q) begin
						best_q       <= util_s1;
						best_valid_q <= 1'b1;
					end else if ($signed({best_q[cks_pkg::UTIL_W-1], best_q}) > ben_fix) begin
						stopped_q <= 1'b1;
					end
				end
				if (cmd.pos_inc) begin
					pos_q <= (pos_q == cks_pkg::IDX_W'(cks_pkg::BOOK_DEPTH - 1)) ?
					         '0 : pos_q + cks_pkg::IDX_W'(1);
				end
			end
			if (cmd.out_single || cmd.out_entry) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Scan and emission control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			sel_valid_q <= 1'b0;
			emitted_q   <= '0;
			emit_n_q    <= '0;
		end else begin
			if (cmd.scan_start || cmd.emit_start || cmd.out_entry) begin
				cnt_q       <= '0;
				sel_valid_q <= 1'b0;
			end else if (cmd.scan_step) begin
				cnt_q <= cnt_q + SW'(1);
			end else if (cmd.emit_step) begin
				cnt_q <= cnt_q + SW'(1);
				if (is_min) sel_valid_q <= 1'b1;
			end
			if (cmd.emit_start) begin
				emitted_q <= '0;
				emit_n_q  <= '0;
			end else if (cmd.out_entry) begin
				emitted_q[sel_slot_q] <= 1'b1;
				emit_n_q <= emit_n_q + SW'(1);
			end
		end
	end

	// Data registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			time_q    <= slot_time;
			owned_q   <= owned_by_user;
			offer_q   <= has_offer;
			cost_in_q <= offer_cost;
			last_q    <= last_slot;
		end
		if (cmd.append) begin
			heap_cost_q[SW'(size_q)] <= cur_cost;
			heap_idx_q[SW'(size_q)]  <= pos_q;
		end
		if (cmd.scan_step && is_max) begin
			max_cost_q <= rd_cost;
			max_idx_q  <= rd_idx;
			max_slot_q <= cnt_q;
		end
		if (cmd.replace && cur_cost < max_cost_q) begin
			heap_cost_q[max_slot_q] <= cur_cost;
			heap_idx_q[max_slot_q]  <= pos_q;
		end
		if (cmd.util) begin
			util_s1 <= util_sat;
			full_s1 <= size_q == p_eff;
		end
		if (cmd.best && full_s1 && emit_q && (!best_valid_q || util_s1 > best_q)) begin
			bset_cost_q <= heap_cost_q;
			bset_idx_q  <= heap_idx_q;
		end
		if (cmd.emit_step && is_min) begin
			sel_cost_q <= e_cost;
			sel_idx_q  <= e_idx;
			sel_slot_q <= cnt_q;
		end
		if (cmd.out_single) begin
			out_idx_q   <= '0;
			out_cost_q  <= '0;
			out_util_q  <= best_q;
			out_found_q <= best_valid_q;
			out_last_q  <= 1'b1;
		end else if (cmd.out_entry) begin
			out_idx_q   <= cks_pkg::OIDX_W'(sel_idx_q);
			out_cost_q  <= sel_cost_q;
			out_util_q  <= best_q;
			out_found_q <= 1'b1;
			out_last_q  <= sts.final_entry;
		end
	end

	assign out_valid    = out_valid_q;
	assign chosen_index = out_idx_q;
	assign chosen_cost  = out_cost_q;
	assign peak_utility = out_util_q;
	assign set_found    = out_found_q;
	assign last_result  = out_last_q;
endmodule
`default_nettype wire

>>> rtl/cheapest_k_slot_selector.sv
// A skipped slot passes through S_IDLE, S_CHECK and S_FINISH; one admitted into a set
// that is not yet full also passes through S_UTIL and S_BEST. Once the set holds pick_count
// slots, the largest member is first found by a scan over the heap registers, one entry per cycle.
// The last slot adds S_EMIT_INIT, then a minimum scan over the best set per result when the set
// is emitted, or the single result otherwise; each result can be held by output stalls.
// Asynchronous active-low reset clears the run state and loads the register defaults.
`default_nettype none
module cheapest_k_slot_selector (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [cks_pkg::TIME_W-1:0]        slot_time,
	input  wire logic                              owned_by_user,
	input  wire logic                              has_offer,
	input  wire logic signed [cks_pkg::COST_W-1:0] offer_cost,
	input  wire logic                              last_slot,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [cks_pkg::OIDX_W-1:0]             chosen_index,
	output logic signed [cks_pkg::COST_W-1:0]      chosen_cost,
	output logic signed [cks_pkg::UTIL_W-1:0]      peak_utility,
	output logic                                   set_found,
	output logic                                   last_result,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [2:0]                        cfg_index,
	input  wire logic [31:0]                       cfg_data
);
	cks_pkg::cmd_t cmd;
	cks_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	cks_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cks_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.slot_time     (slot_time),
		.owned_by_user (owned_by_user),
		.has_offer     (has_offer),
		.offer_cost    (offer_cost),
		.last_slot     (last_slot),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.chosen_index  (chosen_index),
		.chosen_cost   (chosen_cost),
		.peak_utility  (peak_utility),
		.set_found     (set_found),
		.last_result   (last_result)
	);
endmodule
`default_nettype wire

>>> rtl/cks_checker.sv
`default_nettype none
`include "cheapest_k_slot_selector_defines.svh"
module cks_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        last_slot,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [9:0]  chosen_index,
	input wire logic [47:0] peak_utility,
	input wire logic        set_found,
	input wire logic        last_result
);
	`CKS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(chosen_index) && $stable(peak_utility), "stalled output beat changed")
	`CKS_ASSERT_NXT(a_no_early_result, in_valid && in_ready && !last_slot, !$rose(out_valid), "result appeared after a non-final slot")
	`CKS_ASSERT_IMP(a_empty_single, out_valid && !set_found, last_result, "result without a set is not final")
	`CKS_ASSERT_IMP(a_busy_emit, out_valid && !last_result, !in_ready, "input taken while a set is being emitted")
endmodule

bind cheapest_k_slot_selector cks_checker u_cks_checker (.*);
`default_nettype wire
